### src/flba_pkg.sv
// Shared constants, types and codes for the free-list block allocator.
`timescale 1ns / 1ps

package flba_pkg;

   // Heap geometry.
   localparam int unsigned HEAP_GRANULES   = 1024;
   localparam int unsigned GRANULE_BYTES   = 16;
   localparam int unsigned HEADER_BYTES    = 16;
   localparam int unsigned MIN_BLOCK_BYTES = 32;
   localparam int unsigned MIN_GRANULES    =
      (MIN_BLOCK_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;

   // Derived widths.
   localparam int unsigned GRAN_W     = $clog2(HEAP_GRANULES);
   localparam int unsigned SIZE_W     = GRAN_W + 1;
   localparam int unsigned GRAN_SHIFT = $clog2(GRANULE_BYTES);
   localparam int unsigned BYTES_W    = 15;
   localparam int unsigned OFFSET_W   = 14;

   typedef logic [GRAN_W-1:0]   gran_type;
   typedef logic [SIZE_W-1:0]   size_type;
   typedef logic [BYTES_W-1:0]  bytes_type;
   typedef logic [OFFSET_W-1:0] offset_type;

   // Fit policy codes; the unused code behaves as next fit.
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_NEXT  = 2'd2;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_NO_FIT,
      ERR_BAD_FREE
   } err_type;

   // One heap entry: boundary tag plus free list links.
   typedef struct packed {
      size_type size;
      logic     used;
      logic     pvalid;
      gran_type prev;
      gran_type fnext;
      gran_type fprev;
   } mem_word_type;

   // Per-field write enables; prev covers pvalid and prev.
   typedef struct packed {
      logic size;
      logic used;
      logic prev;
      logic fnext;
      logic fprev;
   } mem_mask_type;

   typedef struct packed {
      gran_type     addr;
      mem_mask_type wmask;
      mem_word_type wdata;
   } mem_req_type;

   typedef struct packed {
      logic       op;
      bytes_type  request_size;
      offset_type free_offset;
   } req_item_type;

   typedef struct packed {
      bytes_type  peak;
      bytes_type  used;
      err_type    err;
      offset_type payload;
      logic       ok;
   } result_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_A_SRCH,
      S_A_RDH,
      S_A_CAP,
      S_UNL,
      S_UNL2,
      S_A_SPLIT,
      S_A_AFTER,
      S_A_HEAD,
      S_INS,
      S_INS2,
      S_INS3,
      S_INS4,
      S_FIN,
      S_F_WALK,
      S_F_FREE,
      S_F_RDNB,
      S_F_NB,
      S_F_MW,
      S_F_MP,
      S_F_PRV,
      S_F_PB,
      S_DONE
   } state_type;

   // Granule count to bytes.
   function automatic bytes_type bytes_of(size_type s);
      return bytes_type'(32'(s) << GRAN_SHIFT);
   endfunction

endpackage

### src/flba_mem.sv
// Heap tag and link memory with per-field write enables and registered read.
`timescale 1ns / 1ps

module flba_mem (
   input  logic                  clock,
   input  flba_pkg::mem_req_type mem_req,
   output flba_pkg::mem_word_type mem_rdata
);

   flba_pkg::mem_word_type mem_array [flba_pkg::HEAP_GRANULES];
   flba_pkg::mem_word_type rdata_ff;

   // Single port: masked field writes and a read-first read at one address.
   always_ff @(posedge clock) begin
      if (mem_req.wmask.size) begin
         mem_array[mem_req.addr].size <= mem_req.wdata.size;
      end
      if (mem_req.wmask.used) begin
         mem_array[mem_req.addr].used <= mem_req.wdata.used;
      end
      if (mem_req.wmask.prev) begin
         mem_array[mem_req.addr].pvalid <= mem_req.wdata.pvalid;
         mem_array[mem_req.addr].prev   <= mem_req.wdata.prev;
      end
      if (mem_req.wmask.fnext) begin
         mem_array[mem_req.addr].fnext <= mem_req.wdata.fnext;
      end
      if (mem_req.wmask.fprev) begin
         mem_array[mem_req.addr].fprev <= mem_req.wdata.fprev;
      end
      rdata_ff <= mem_array[mem_req.addr];
   end

   assign mem_rdata = rdata_ff;

endmodule

### src/flba_ctrl.sv
// Sequencer that walks and updates the heap memory for allocate and free items.
`timescale 1ns / 1ps

module flba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             fit_policy,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  flba_pkg::req_item_type req_item,
   output flba_pkg::mem_req_type  mem_req,
   input  flba_pkg::mem_word_type mem_rdata,
   output logic                   res_valid,
   input  logic                   res_ready,
   output flba_pkg::result_type   result
);

   localparam flba_pkg::size_type HEAP_SZ = flba_pkg::size_type'(flba_pkg::HEAP_GRANULES);
   localparam flba_pkg::size_type MIN_SZ  = flba_pkg::size_type'(flba_pkg::MIN_GRANULES);
   localparam flba_pkg::size_type OVER_SZ =
      flba_pkg::size_type'(flba_pkg::HEAP_GRANULES + 1);

   flba_pkg::state_type  state_ff, state_in, ret_ff, ret_in;
   logic                 op_ff, op_in;
   flba_pkg::size_type   need_ff, need_in;
   flba_pkg::gran_type   start_ff, start_in, n_ff, n_in;
   logic                 have_ff, have_in;
   flba_pkg::gran_type   best_ff, best_in;
   flba_pkg::size_type   best_sz_ff, best_sz_in;
   flba_pkg::gran_type   g_ff, g_in, s_ff, s_in;
   flba_pkg::size_type   gsize_ff, gsize_in, c_ff, c_in;
   logic                 g_pvalid_ff, g_pvalid_in;
   flba_pkg::gran_type   g_prev_ff, g_prev_in;
   flba_pkg::gran_type   u_node_ff, u_node_in, u_next_ff, u_next_in, u_prev_ff, u_prev_in;
   flba_pkg::gran_type   after_ff, after_in;
   logic                 merge_prev_ff, merge_prev_in;
   flba_pkg::gran_type   head_ff, head_in, cur_ff, cur_in;
   logic                 hv_ff, hv_in, cv_ff, cv_in;
   flba_pkg::bytes_type  used_ff, used_in, peak_ff, peak_in;
   flba_pkg::result_type res_ff, res_in;

   // Shared conditions.
   logic                req_fire, is_best, is_first, fit_hit, best_take, srch_wrap;
   logic                walk_at, walk_end, split, after_ok, unl_single;
   flba_pkg::size_type  walk_next, remain, after_g;
   flba_pkg::gran_type  ins_node, srch_start;
   flba_pkg::bytes_type size_eff, alloc_sum, off_rel;
   logic [16:0]         need_sum, need_full;
   flba_pkg::size_type  need_raw, need_eff;
   logic                fmt_ok;

   always_comb begin
      req_fire   = req_valid && req_ready;
      is_best    = fit_policy == flba_pkg::POLICY_BEST;
      is_first   = fit_policy == flba_pkg::POLICY_FIRST;
      fit_hit    = mem_rdata.size >= need_ff;
      best_take  = fit_hit && (!have_ff || mem_rdata.size < best_sz_ff);
      srch_wrap  = mem_rdata.fnext == start_ff;
      walk_at    = c_ff == {1'b0, g_ff};
      walk_next  = c_ff + mem_rdata.size;
      walk_end   = walk_next >= HEAP_SZ;
      remain     = gsize_ff - need_ff;
      split      = remain >= MIN_SZ;
      after_g    = {1'b0, g_ff} + gsize_ff;
      after_ok   = after_g < HEAP_SZ;
      unl_single = u_next_ff == u_node_ff;
      ins_node   = (op_ff == flba_pkg::OP_ALLOC) ? s_ff : g_ff;
      alloc_sum  = used_ff + flba_pkg::bytes_of(split ? need_ff : gsize_ff);
      srch_start = (is_best || is_first || !cv_ff) ? head_ff : cur_ff;
      // Request size to granules, header included, with the minimum floor.
      size_eff   = (req_item.request_size == '0) ? flba_pkg::bytes_type'(1)
                                                 : req_item.request_size;
      need_sum   = 17'(flba_pkg::HEADER_BYTES) + 17'(size_eff)
                 + 17'(flba_pkg::GRANULE_BYTES - 1);
      need_full  = need_sum >> flba_pkg::GRAN_SHIFT;
      // A request needing more granules than the heap has is clamped to one granule more than the heap holds.
      need_raw   = (need_full > 17'(flba_pkg::HEAP_GRANULES)) ? OVER_SZ
                                                              : flba_pkg::size_type'(need_full);
      need_eff   = (need_raw < MIN_SZ) ? MIN_SZ : need_raw;
      // Free offset must sit on a granule payload inside the heap.
      off_rel    = 15'(req_item.free_offset) - 15'(flba_pkg::HEADER_BYTES);
      fmt_ok     = (req_item.free_offset >= 14'(flba_pkg::HEADER_BYTES))
                && ((off_rel & 15'(flba_pkg::GRANULE_BYTES - 1)) == '0)
                && ((off_rel >> flba_pkg::GRAN_SHIFT) < 15'(flba_pkg::HEAP_GRANULES));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         flba_pkg::S_INIT: state_in = flba_pkg::S_IDLE;
         flba_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_item.op == flba_pkg::OP_FREE) begin
                  state_in = fmt_ok ? flba_pkg::S_F_WALK : flba_pkg::S_DONE;
               end else begin
                  state_in = hv_ff ? flba_pkg::S_A_SRCH : flba_pkg::S_DONE;
               end
            end
         end
         flba_pkg::S_A_SRCH: begin
            if (fit_hit && !is_best) begin
               state_in = flba_pkg::S_UNL;
            end else if (srch_wrap) begin
               state_in = (is_best && (have_ff || best_take)) ? flba_pkg::S_A_RDH
                                                              : flba_pkg::S_DONE;
            end
         end
         flba_pkg::S_A_RDH:   state_in = flba_pkg::S_A_CAP;
         flba_pkg::S_A_CAP:   state_in = flba_pkg::S_UNL;
         flba_pkg::S_UNL:     state_in = unl_single ? ret_ff : flba_pkg::S_UNL2;
         flba_pkg::S_UNL2:    state_in = ret_ff;
         flba_pkg::S_A_SPLIT: state_in = split ? flba_pkg::S_A_AFTER : flba_pkg::S_FIN;
         flba_pkg::S_A_AFTER: state_in = flba_pkg::S_A_HEAD;
         flba_pkg::S_A_HEAD:  state_in = flba_pkg::S_INS;
         flba_pkg::S_INS:     state_in = hv_ff ? flba_pkg::S_INS2 : flba_pkg::S_FIN;
         flba_pkg::S_INS2:    state_in = flba_pkg::S_INS3;
         flba_pkg::S_INS3:    state_in = flba_pkg::S_INS4;
         flba_pkg::S_INS4:    state_in = flba_pkg::S_FIN;
         flba_pkg::S_FIN:     state_in = flba_pkg::S_DONE;
         flba_pkg::S_F_WALK: begin
            if (walk_at) begin
               state_in = mem_rdata.used ? flba_pkg::S_F_FREE : flba_pkg::S_DONE;
            end else if (mem_rdata.size == '0 || walk_end) begin
               state_in = flba_pkg::S_DONE;
            end
         end
         flba_pkg::S_F_FREE: state_in = after_ok ? flba_pkg::S_F_RDNB : flba_pkg::S_F_PRV;
         flba_pkg::S_F_RDNB: state_in = flba_pkg::S_F_NB;
         flba_pkg::S_F_NB:   state_in = mem_rdata.used ? flba_pkg::S_F_PRV : flba_pkg::S_UNL;
         flba_pkg::S_F_MW:   state_in = flba_pkg::S_F_MP;
         flba_pkg::S_F_MP:   state_in = merge_prev_ff ? flba_pkg::S_INS : flba_pkg::S_F_PRV;
         flba_pkg::S_F_PRV:  state_in = g_pvalid_ff ? flba_pkg::S_F_PB : flba_pkg::S_INS;
         flba_pkg::S_F_PB:   state_in = mem_rdata.used ? flba_pkg::S_INS : flba_pkg::S_UNL;
         flba_pkg::S_DONE:   state_in = res_ready ? flba_pkg::S_IDLE : flba_pkg::S_DONE;
         default:            state_in = flba_pkg::S_IDLE;
      endcase
   end

   // Memory accesses and datapath register updates.
   always_comb begin
      ret_in = ret_ff; op_in = op_ff; need_in = need_ff; start_in = start_ff;
      n_in = n_ff; have_in = have_ff; best_in = best_ff; best_sz_in = best_sz_ff;
      g_in = g_ff; s_in = s_ff; gsize_in = gsize_ff; c_in = c_ff;
      g_pvalid_in = g_pvalid_ff; g_prev_in = g_prev_ff;
      u_node_in = u_node_ff; u_next_in = u_next_ff; u_prev_in = u_prev_ff;
      after_in = after_ff; merge_prev_in = merge_prev_ff;
      head_in = head_ff; hv_in = hv_ff; cur_in = cur_ff; cv_in = cv_ff;
      used_in = used_ff; peak_in = peak_ff; res_in = res_ff;
      mem_req = '0;
      case (state_ff)
         // Granule zero holds the whole heap as one free block.
         flba_pkg::S_INIT: begin
            mem_req.wmask      = '1;
            mem_req.wdata.size = HEAP_SZ;
         end
         flba_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in      = req_item.op;
               need_in    = need_eff;
               start_in   = srch_start;
               n_in       = srch_start;
               have_in    = 1'b0;
               g_in       = flba_pkg::gran_type'(off_rel >> flba_pkg::GRAN_SHIFT);
               c_in       = '0;
               res_in     = '0;
               res_in.used = used_ff;
               res_in.peak = peak_ff;
               if (req_item.op == flba_pkg::OP_FREE) begin
                  res_in.err = flba_pkg::ERR_BAD_FREE;
               end else begin
                  res_in.err   = flba_pkg::ERR_NO_FIT;
                  mem_req.addr = srch_start;
               end
            end
         end
         // One free list entry per cycle; the next read is issued at once.
         flba_pkg::S_A_SRCH: begin
            if (best_take) begin
               have_in    = 1'b1;
               best_in    = n_ff;
               best_sz_in = mem_rdata.size;
            end
            if (fit_hit && !is_best) begin
               g_in      = n_ff;
               gsize_in  = mem_rdata.size;
               u_node_in = n_ff;
               u_next_in = mem_rdata.fnext;
               u_prev_in = mem_rdata.fprev;
               ret_in    = flba_pkg::S_A_SPLIT;
               if (!is_first) begin
                  cur_in = mem_rdata.fnext;
                  cv_in  = 1'b1;
               end
            end else begin
               n_in         = mem_rdata.fnext;
               mem_req.addr = mem_rdata.fnext;
            end
         end
         flba_pkg::S_A_RDH: mem_req.addr = best_ff;
         flba_pkg::S_A_CAP: begin
            g_in      = best_ff;
            gsize_in  = mem_rdata.size;
            u_node_in = best_ff;
            u_next_in = mem_rdata.fnext;
            u_prev_in = mem_rdata.fprev;
            ret_in    = flba_pkg::S_A_SPLIT;
         end
         // Unlink: bypass the node from both neighbors, or empty the list when it is the only node.
         flba_pkg::S_UNL: begin
            if (unl_single) begin
               hv_in = 1'b0;
               cv_in = 1'b0;
            end else begin
               mem_req.addr        = u_prev_ff;
               mem_req.wmask.fnext = 1'b1;
               mem_req.wdata.fnext = u_next_ff;
            end
         end
         flba_pkg::S_UNL2: begin
            mem_req.addr        = u_next_ff;
            mem_req.wmask.fprev = 1'b1;
            mem_req.wdata.fprev = u_prev_ff;
            if (head_ff == u_node_ff) begin
               head_in = u_next_ff;
            end
            if (cv_ff && cur_ff == u_node_ff) begin
               cur_in = u_next_ff;
            end
         end
         // Either carve off the tail as a new free block or take it all.
         flba_pkg::S_A_SPLIT: begin
            if (split) begin
               s_in                 = g_ff + need_ff[flba_pkg::GRAN_W-1:0];
               mem_req.addr         = g_ff + need_ff[flba_pkg::GRAN_W-1:0];
               mem_req.wmask.size   = 1'b1;
               mem_req.wmask.used   = 1'b1;
               mem_req.wmask.prev   = 1'b1;
               mem_req.wdata.size   = remain;
               mem_req.wdata.pvalid = 1'b1;
               mem_req.wdata.prev   = g_ff;
            end else begin
               mem_req.addr       = g_ff;
               mem_req.wmask.used = 1'b1;
               mem_req.wdata.used = 1'b1;
               used_in            = alloc_sum;
               peak_in            = (alloc_sum > peak_ff) ? alloc_sum : peak_ff;
            end
         end
         flba_pkg::S_A_AFTER: begin
            if (after_ok) begin
               mem_req.addr         = after_g[flba_pkg::GRAN_W-1:0];
               mem_req.wmask.prev   = 1'b1;
               mem_req.wdata.pvalid = 1'b1;
               mem_req.wdata.prev   = s_ff;
            end
         end
         flba_pkg::S_A_HEAD: begin
            mem_req.addr       = g_ff;
            mem_req.wmask.size = 1'b1;
            mem_req.wmask.used = 1'b1;
            mem_req.wdata.size = need_ff;
            mem_req.wdata.used = 1'b1;
            used_in            = alloc_sum;
            peak_in            = (alloc_sum > peak_ff) ? alloc_sum : peak_ff;
         end
         // Insert after the head, or start a new list.
         flba_pkg::S_INS: begin
            if (!cv_ff) begin
               cur_in = ins_node;
               cv_in  = 1'b1;
            end
            if (!hv_ff) begin
               head_in             = ins_node;
               hv_in               = 1'b1;
               mem_req.addr        = ins_node;
               mem_req.wmask.fnext = 1'b1;
               mem_req.wmask.fprev = 1'b1;
               mem_req.wdata.fnext = ins_node;
               mem_req.wdata.fprev = ins_node;
            end else begin
               mem_req.addr = head_ff;
            end
         end
         flba_pkg::S_INS2: begin
            after_in            = mem_rdata.fnext;
            mem_req.addr        = ins_node;
            mem_req.wmask.fnext = 1'b1;
            mem_req.wmask.fprev = 1'b1;
            mem_req.wdata.fnext = mem_rdata.fnext;
            mem_req.wdata.fprev = head_ff;
         end
         flba_pkg::S_INS3: begin
            mem_req.addr        = after_ff;
            mem_req.wmask.fprev = 1'b1;
            mem_req.wdata.fprev = ins_node;
         end
         flba_pkg::S_INS4: begin
            mem_req.addr        = head_ff;
            mem_req.wmask.fnext = 1'b1;
            mem_req.wdata.fnext = ins_node;
         end
         flba_pkg::S_FIN: begin
            res_in.ok   = 1'b1;
            res_in.err  = flba_pkg::ERR_NONE;
            res_in.used = used_ff;
            res_in.peak = peak_ff;
            res_in.payload = (op_ff == flba_pkg::OP_ALLOC)
               ? flba_pkg::offset_type'((32'(g_ff) << flba_pkg::GRAN_SHIFT)
                                        + flba_pkg::HEADER_BYTES)
               : '0;
         end
         // Physical chain walk from granule zero to validate the offset.
         flba_pkg::S_F_WALK: begin
            if (walk_at) begin
               gsize_in    = mem_rdata.size;
               g_pvalid_in = mem_rdata.pvalid;
               g_prev_in   = mem_rdata.prev;
            end else begin
               c_in         = walk_next;
               mem_req.addr = walk_next[flba_pkg::GRAN_W-1:0];
            end
         end
         flba_pkg::S_F_FREE: begin
            mem_req.addr       = g_ff;
            mem_req.wmask.used = 1'b1;
            mem_req.wdata.used = 1'b0;
            used_in            = used_ff - flba_pkg::bytes_of(gsize_ff);
         end
         flba_pkg::S_F_RDNB: mem_req.addr = after_g[flba_pkg::GRAN_W-1:0];
         flba_pkg::S_F_NB: begin
            if (!mem_rdata.used) begin
               u_node_in     = after_g[flba_pkg::GRAN_W-1:0];
               u_next_in     = mem_rdata.fnext;
               u_prev_in     = mem_rdata.fprev;
               gsize_in      = gsize_ff + mem_rdata.size;
               merge_prev_in = 1'b0;
               ret_in        = flba_pkg::S_F_MW;
            end
         end
         flba_pkg::S_F_MW: begin
            mem_req.addr       = g_ff;
            mem_req.wmask.size = 1'b1;
            mem_req.wdata.size = gsize_ff;
         end
         flba_pkg::S_F_MP: begin
            if (after_ok) begin
               mem_req.addr         = after_g[flba_pkg::GRAN_W-1:0];
               mem_req.wmask.prev   = 1'b1;
               mem_req.wdata.pvalid = 1'b1;
               mem_req.wdata.prev   = g_ff;
            end
         end
         flba_pkg::S_F_PRV: mem_req.addr = g_prev_ff;
         flba_pkg::S_F_PB: begin
            if (!mem_rdata.used) begin
               u_node_in     = g_prev_ff;
               u_next_in     = mem_rdata.fnext;
               u_prev_in     = mem_rdata.fprev;
               gsize_in      = gsize_ff + mem_rdata.size;
               g_in          = g_prev_ff;
               merge_prev_in = 1'b1;
               ret_in        = flba_pkg::S_F_MW;
            end
         end
         flba_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flba_pkg::S_INIT;
         head_ff  <= '0;
         hv_ff    <= 1'b1;
         cur_ff   <= '0;
         cv_ff    <= 1'b1;
         used_ff  <= '0;
         peak_ff  <= '0;
         ret_ff   <= flba_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         hv_ff    <= hv_in;
         cur_ff   <= cur_in;
         cv_ff    <= cv_in;
         used_ff  <= used_in;
         peak_ff  <= peak_in;
         ret_ff   <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; need_ff <= need_in; start_ff <= start_in; n_ff <= n_in;
      have_ff <= have_in; best_ff <= best_in; best_sz_ff <= best_sz_in;
      g_ff <= g_in; s_ff <= s_in; gsize_ff <= gsize_in; c_ff <= c_in;
      g_pvalid_ff <= g_pvalid_in; g_prev_ff <= g_prev_in;
      u_node_ff <= u_node_in; u_next_ff <= u_next_in; u_prev_ff <= u_prev_in;
      after_ff <= after_in; merge_prev_ff <= merge_prev_in; res_ff <= res_in;
   end

   assign req_ready = state_ff == flba_pkg::S_IDLE;
   assign res_valid = state_ff == flba_pkg::S_DONE;
   assign result    = res_ff;

endmodule

### src/free_list_block_allocator.sv
// Operation: an allocate searches the free list entry by entry, then unlinks, splits and
// relinks its block; a free walks the blocks from granule zero, then merges with free
// neighbors and relinks. Each item ends with its result.
// Throughput: one item at a time; the next is taken the cycle after its result is registered.
// Reset: synchronous; the first cycle after reset writes granule zero as one free block,
// then the block is ready. The fit policy resets to first fit.
`timescale 1ns / 1ps

module free_list_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // request_size[14:0], free_offset[28:15], zero pad
   input  logic        req_tuser,  // operation: 0 allocate, 1 free
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // ok, payload_offset[14:1], error_code[16:15],
                                   // used_bytes[31:17], peak_used_bytes[46:32], zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata   // fit_policy
);

   logic [1:0]             policy_ff;
   flba_pkg::req_item_type req_item;
   flba_pkg::mem_req_type  mem_req;
   flba_pkg::mem_word_type mem_rdata;
   logic                   res_valid, res_ready;
   flba_pkg::result_type   result;
   logic                   out_valid_ff;
   flba_pkg::result_type   out_ff;

   // Fit policy register.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= flba_pkg::POLICY_FIRST;
      end else if (csr_we) begin
         policy_ff <= csr_wdata;
      end
   end

   assign req_item.op           = req_tuser;
   assign req_item.request_size = req_tdata[14:0];
   assign req_item.free_offset  = req_tdata[28:15];

   flba_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   flba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fit_policy (policy_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .result     (result)
   );

   // Output register holds one finished item.
   assign res_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff};

   // A result reports success exactly when it carries no error.
   a_ok_err: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.ok == (out_ff.err == flba_pkg::ERR_NONE)))
      else $error("ok flag disagrees with error code");

   // The peak never falls below the current use.
   a_peak: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.peak >= out_ff.used))
      else $error("peak below used bytes");

   // An accepted item keeps the sequencer busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while busy");

   // A result handed over is shown at the output in the next cycle.
   a_load: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> out_valid_ff)
      else $error("result lost on hand-over");

endmodule

### dv/free_list_block_allocator_test.sv
// Self-checking test of the free-list block allocator: predicted heap against the block.
`timescale 1ns / 1ps

module free_list_block_allocator_test;

   localparam int unsigned LIMIT_CYCLES = 3000000;

   // Result fields as the block packs them.
   typedef struct {
      logic                 ok;
      flba_pkg::offset_type payload;
      flba_pkg::err_type    err;
      flba_pkg::bytes_type  used;
      flba_pkg::bytes_type  peak;
   } heap_result_type;

   // Scoreboard: keeps its own heap image and the queue of predicted results.
   class heap_scoreboard_type;
      int unsigned blk_size [flba_pkg::HEAP_GRANULES];
      bit          blk_used [flba_pkg::HEAP_GRANULES];
      int unsigned phys_prev [flba_pkg::HEAP_GRANULES];
      bit          phys_prev_ok [flba_pkg::HEAP_GRANULES];
      int unsigned link_next [flba_pkg::HEAP_GRANULES];
      int unsigned link_prev [flba_pkg::HEAP_GRANULES];
      int unsigned head;
      bit          head_ok;
      int unsigned cursor;
      bit          cursor_ok;
      int unsigned used_sum;
      int unsigned peak_sum;
      logic [1:0]  policy;
      heap_result_type pending[$];
      int unsigned mismatches;
      // Payload offsets of live allocations, used to aim frees.
      int unsigned live[$];

      function new();
         foreach (blk_size[i]) begin
            blk_size[i] = 0; blk_used[i] = 0; phys_prev[i] = 0;
            phys_prev_ok[i] = 0; link_next[i] = 0; link_prev[i] = 0;
         end
         blk_size[0] = flba_pkg::HEAP_GRANULES;
         head = 0; head_ok = 1; cursor = 0; cursor_ok = 1;
         used_sum = 0; peak_sum = 0; policy = flba_pkg::POLICY_FIRST; mismatches = 0;
      endfunction

      function void link_in(int unsigned n);
         int unsigned after;
         if (!head_ok) begin
            head = n; head_ok = 1; link_next[n] = n; link_prev[n] = n;
         end else begin
            after = link_next[head];
            link_next[n] = after; link_prev[n] = head;
            link_prev[after] = n; link_next[head] = n;
         end
         if (!cursor_ok) begin
            cursor = n; cursor_ok = 1;
         end
      endfunction

      function void link_out(int unsigned n);
         int unsigned nx, pv;
         nx = link_next[n]; pv = link_prev[n];
         if (nx == n) begin
            head_ok = 0; cursor_ok = 0;
            return;
         end
         link_next[pv] = nx; link_prev[nx] = pv;
         if (head == n) head = nx;
         if (cursor_ok && cursor == n) cursor = nx;
      endfunction

      function bit find_block(int unsigned need, output int unsigned hit);
         int unsigned n, start, best_sz;
         bit have;
         have = 0; best_sz = 0; hit = 0;
         if (!head_ok) return 0;
         if (policy == flba_pkg::POLICY_FIRST || policy == flba_pkg::POLICY_BEST) begin
            n = head;
            for (int s = 0; s < flba_pkg::HEAP_GRANULES; s++) begin
               if (blk_size[n] >= need && (!have || blk_size[n] < best_sz)) begin
                  have = 1; hit = n; best_sz = blk_size[n];
                  if (policy == flba_pkg::POLICY_FIRST) return 1;
               end
               n = link_next[n];
               if (n == head) break;
            end
            return have;
         end
         // Next fit, also for the unused policy code.
         start = cursor_ok ? cursor : head;
         n = start;
         for (int s = 0; s < flba_pkg::HEAP_GRANULES; s++) begin
            if (blk_size[n] >= need) begin
               cursor = link_next[n]; cursor_ok = 1; hit = n;
               return 1;
            end
            n = link_next[n];
            if (n == start) break;
         end
         return 0;
      endfunction

      function bit starts_block(int unsigned g);
         int unsigned c;
         c = 0;
         for (int s = 0; s < flba_pkg::HEAP_GRANULES && c < flba_pkg::HEAP_GRANULES; s++) begin
            if (c == g) return 1;
            if (blk_size[c] == 0) return 0;
            c += blk_size[c];
         end
         return 0;
      endfunction

      // Note an accepted request and queue the result it must produce.
      function void note_request(logic op, flba_pkg::bytes_type req_size,
                                 flba_pkg::offset_type off);
         heap_result_type r;
         int unsigned sz, need, h, rem, s, g, nb, pb;
         bit good;
         r.ok = 0; r.payload = 0; r.err = flba_pkg::ERR_NONE;
         if (op == flba_pkg::OP_ALLOC) begin
            sz = (req_size == 0) ? 1 : req_size;
            need = (flba_pkg::HEADER_BYTES + sz + flba_pkg::GRANULE_BYTES - 1)
                 / flba_pkg::GRANULE_BYTES;
            if (need < flba_pkg::MIN_GRANULES) need = flba_pkg::MIN_GRANULES;
            if (!find_block(need, h)) begin
               r.err = flba_pkg::ERR_NO_FIT;
            end else begin
               link_out(h);
               rem = blk_size[h] - need;
               if (rem >= flba_pkg::MIN_GRANULES) begin
                  s = h + need;
                  blk_size[s] = rem; blk_used[s] = 0;
                  phys_prev[s] = h; phys_prev_ok[s] = 1;
                  if (s + rem < flba_pkg::HEAP_GRANULES) begin
                     phys_prev[s + rem] = s; phys_prev_ok[s + rem] = 1;
                  end
                  blk_size[h] = need;
                  blk_used[h] = 1;
                  link_in(s);
               end else begin
                  blk_used[h] = 1;
               end
               used_sum += blk_size[h] * flba_pkg::GRANULE_BYTES;
               if (used_sum > peak_sum) peak_sum = used_sum;
               r.ok = 1;
               r.payload = flba_pkg::offset_type'(h * flba_pkg::GRANULE_BYTES
                                                  + flba_pkg::HEADER_BYTES);
               live.push_back(h * flba_pkg::GRANULE_BYTES + flba_pkg::HEADER_BYTES);
            end
         end else begin
            good = off >= flba_pkg::HEADER_BYTES
                && ((off - flba_pkg::HEADER_BYTES) % flba_pkg::GRANULE_BYTES) == 0;
            g = 0;
            if (good) begin
               g = (off - flba_pkg::HEADER_BYTES) / flba_pkg::GRANULE_BYTES;
               good = g < flba_pkg::HEAP_GRANULES && starts_block(g) && blk_used[g];
            end
            if (!good) begin
               r.err = flba_pkg::ERR_BAD_FREE;
            end else begin
               nb = g + blk_size[g];
               used_sum -= blk_size[g] * flba_pkg::GRANULE_BYTES;
               blk_used[g] = 0;
               // Merge with the following block first, then the preceding one.
               if (nb < flba_pkg::HEAP_GRANULES && !blk_used[nb]) begin
                  link_out(nb);
                  blk_size[g] += blk_size[nb];
                  if (g + blk_size[g] < flba_pkg::HEAP_GRANULES) begin
                     phys_prev[g + blk_size[g]] = g; phys_prev_ok[g + blk_size[g]] = 1;
                  end
               end
               if (phys_prev_ok[g]) begin
                  pb = phys_prev[g];
                  if (pb < flba_pkg::HEAP_GRANULES && !blk_used[pb]) begin
                     link_out(pb);
                     blk_size[pb] += blk_size[g];
                     if (pb + blk_size[pb] < flba_pkg::HEAP_GRANULES) begin
                        phys_prev[pb + blk_size[pb]] = pb;
                        phys_prev_ok[pb + blk_size[pb]] = 1;
                     end
                     g = pb;
                  end
               end
               link_in(g);
               r.ok = 1;
               foreach (live[i]) if (live[i] == off) begin
                  live.delete(i);
                  break;
               end
            end
         end
         r.used = flba_pkg::bytes_type'(used_sum);
         r.peak = flba_pkg::bytes_type'(peak_sum);
         pending.push_back(r);
      endfunction

      function void report(string what, int unsigned got, int unsigned want);
         $display("mismatch %s: got %0d, expected %0d", what, got, want);
         mismatches++;
      endfunction

      // Compare one accepted result with the oldest prediction.
      function void check_result(logic [47:0] data);
         heap_result_type w;
         if (pending.size() == 0) begin
            report("unexpected result", data[31:0], 0);
            return;
         end
         w = pending.pop_front();
         if (data[0] !== w.ok) report("ok", data[0], w.ok);
         if (data[14:1] !== w.payload) report("payload_offset", data[14:1], w.payload);
         if (data[16:15] !== w.err) report("error_code", data[16:15], w.err);
         if (data[31:17] !== w.used) report("used_bytes", data[31:17], w.used);
         if (data[46:32] !== w.peak) report("peak_used_bytes", data[46:32], w.peak);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_wdata = '0;

   heap_scoreboard_type board;
   int unsigned cycle_count = 0;
   int unsigned stall_phase = 0;

   free_list_block_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Result side: stall on its own rolling pattern and check every accepted item.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL free_list_block_allocator");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         stall_phase <= stall_phase + 1;
         case ((stall_phase / 200) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= (stall_phase % 7) < 3;
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // Offer one request and hold it until the block takes it.
   task automatic send_item(logic op, flba_pkg::bytes_type req_size,
                            flba_pkg::offset_type off);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b0, off, req_size};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, req_size, off);
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_policy(logic [1:0] p);
      csr_we <= 1'b1;
      csr_wdata <= p;
      @(posedge clock);
      csr_we <= 1'b0;
      board.policy = p;
   endtask

   task automatic alloc(int unsigned n);
      send_item(flba_pkg::OP_ALLOC, flba_pkg::bytes_type'(n), '0);
   endtask

   task automatic free_at(int unsigned off);
      send_item(flba_pkg::OP_FREE, flba_pkg::bytes_type'($urandom),
                flba_pkg::offset_type'(off));
   endtask

   // Random mix: mostly frees of live blocks and allocations, some bad frees.
   task automatic random_run(int unsigned count);
      int unsigned burst, k;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            pause_sender();
            repeat ($urandom_range(0, 6)) @(posedge clock);
            burst = $urandom_range(1, 20);
         end
         burst--;
         k = $urandom_range(0, 99);
         if (k < 40 && board.live.size() != 0)
            free_at(board.live[$urandom_range(0, board.live.size() - 1)]);
         else if (k < 50)
            free_at($urandom_range(0, 16383));
         else if (k < 55)
            free_at($urandom_range(1, flba_pkg::HEAP_GRANULES - 1) * flba_pkg::GRANULE_BYTES
                    + flba_pkg::HEADER_BYTES);
         else if (k < 60)
            alloc($urandom_range(0, 32767));
         else if (k < 90)
            alloc($urandom_range(0, 200));
         else
            alloc($urandom_range(0, 2000));
      end
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, both operations, bad and double frees.
      alloc(0);
      alloc(1);
      alloc(16384);
      alloc(32767);
      free_at(16);
      free_at(16);
      free_at(0);
      free_at(17);
      free_at(16383);
      free_at(48);
      alloc(16368);
      alloc(100);
      free_at(10922);
      free_at(5461);
      free_at(board.live.size() != 0 ? board.live[0] : 16);
      alloc(16368 - 64);
      alloc(10);
      alloc(10);
      alloc(10);
      while (board.live.size() != 0) free_at(board.live.pop_front());
      drain();

      // Random phases over every policy, including the unused code.
      write_policy(flba_pkg::POLICY_BEST);
      random_run(200);
      drain();
      write_policy(flba_pkg::POLICY_NEXT);
      random_run(200);
      drain();
      write_policy(2'd3);
      random_run(150);
      drain();
      write_policy(flba_pkg::POLICY_FIRST);
      random_run(200);
      drain();
      write_policy(flba_pkg::POLICY_NEXT);
      random_run(150);
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS free_list_block_allocator");
      end else begin
         $display("FAIL free_list_block_allocator");
      end
      $finish;
   end

endmodule
